// ===== hw/rtl/c2dvw_pkg.sv =====
// Package for the 2-D valid convolution block: sizes, codes, FSM state type,
// the command and status structs, and the dimension clamp helpers.
// No dependencies.
package c2dvw_pkg;

    localparam int MAX_IMAGE_DIM  = 64;
    localparam int MAX_KERNEL_DIM = 5;

    localparam int DIM_W      = 7;
    localparam int KDIM_W     = 3;
    localparam int POS_W      = $clog2(MAX_IMAGE_DIM);
    localparam int CNT_W      = $clog2(MAX_KERNEL_DIM + 1);
    localparam int LB_DEPTH   = MAX_KERNEL_DIM * MAX_IMAGE_DIM;
    localparam int LB_AW      = $clog2(LB_DEPTH);
    localparam int VAL_W      = 16;
    localparam int PROD_W     = 2 * VAL_W;
    localparam int SUM_W      = 40;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_ROWS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_COLS = 2'd3;

    localparam logic KIND_WEIGHT = 1'b0;
    localparam logic KIND_PIXEL  = 1'b1;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_RD_ISSUE = 6'b000010,
        ST_RD_CAPT  = 6'b000100,
        ST_MUL      = 6'b001000,
        ST_ACC      = 6'b010000,
        ST_DONE     = 6'b100000
    } t_state;

    typedef struct packed {
        logic take_weight;
        logic take_pixel;
        logic rd_issue;
        logic rd_capt;
        logic clr_acc;
        logic mul;
        logic acc;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic row_last;
        logic term_last;
        logic emit;
        logic out_free;
    } t_sts;

    function automatic logic [DIM_W-1:0] clamp_img(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] res;
        res = v;
        if (v == '0) res = DIM_W'(1);
        else if (v > DIM_W'(MAX_IMAGE_DIM)) res = DIM_W'(MAX_IMAGE_DIM);
        return res;
    endfunction

    function automatic logic [KDIM_W-1:0] clamp_ker(input logic [KDIM_W-1:0] v);
        logic [KDIM_W-1:0] res;
        res = v;
        if (v == '0) res = KDIM_W'(1);
        else if (v > KDIM_W'(MAX_KERNEL_DIM)) res = KDIM_W'(MAX_KERNEL_DIM);
        return res;
    endfunction

endpackage

// ===== hw/rtl/c2dvw_in_if.sv =====
// Input channel of the convolution block: valid/ready plus one item.
// Depends on c2dvw_pkg for field widths.
interface c2dvw_in_if import c2dvw_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    kind;
    logic [2:0]              weight_row;
    logic [2:0]              weight_col;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, kind, weight_row, weight_col, value, input ready);
    modport sink   (input valid, kind, weight_row, weight_col, value, output ready);
endinterface

// ===== hw/rtl/c2dvw_out_if.sv =====
// Output channel of the convolution block: valid/ready plus one result.
// Depends on c2dvw_pkg for field widths.
interface c2dvw_out_if import c2dvw_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [SUM_W-1:0] conv_sum;
    logic [POS_W-1:0]        out_row;
    logic [POS_W-1:0]        out_col;
    logic                    last_of_image;

    modport source (output valid, conv_sum, out_row, out_col, last_of_image, input ready);
    modport sink   (input valid, conv_sum, out_row, out_col, last_of_image, output ready);
endinterface

// ===== hw/rtl/c2dvw_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module c2dvw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 320,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/c2dvw_ctrl.sv =====
// Controller state machine of the convolution block.
// Depends on c2dvw_pkg (state type, command and status structs).
module c2dvw_ctrl import c2dvw_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_kind,
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_cmd o_cmd
);
    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = (r_state == ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_kind == KIND_PIXEL) begin
                        o_cmd.take_pixel = 1'b1;
                        n_state          = ST_RD_ISSUE;
                    end else begin
                        o_cmd.take_weight = 1'b1;
                    end
                end
            end
            ST_RD_ISSUE: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = ST_RD_CAPT;
            end
            ST_RD_CAPT: begin
                o_cmd.rd_capt = 1'b1;
                if (!i_sts.row_last) begin
                    n_state = ST_RD_ISSUE;
                end else if (i_sts.emit) begin
                    o_cmd.clr_acc = 1'b1;
                    n_state       = ST_MUL;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = i_sts.term_last ? ST_DONE : ST_MUL;
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_pixel_starts_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.take_pixel |=> (r_state == ST_RD_ISSUE))
        else $error("pixel beat did not start the line-buffer read");

    a_mul_then_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) |=> (r_state == ST_ACC))
        else $error("product was not accumulated");

    a_mac_only_on_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.clr_acc |-> i_sts.emit)
        else $error("MAC started for a pixel that yields no result");
endmodule

// ===== hw/rtl/c2dvw_dp.sv =====
// Datapath of the convolution block: config, weights, line buffers, window
// taps, the shared multiplier and accumulator, and the output register.
// Depends on c2dvw_pkg and c2dvw_ram.
module c2dvw_dp import c2dvw_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  t_cmd                    i_cmd,
    output t_sts                    o_sts,
    input  logic [2:0]              i_weight_row,
    input  logic [2:0]              i_weight_col,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic                    i_out_ready,
    output logic                    o_out_valid,
    output logic signed [SUM_W-1:0] o_conv_sum,
    output logic [POS_W-1:0]        o_out_row,
    output logic [POS_W-1:0]        o_out_col,
    output logic                    o_last_of_image
);
    localparam int SUMK_W = CNT_W + 2;

    logic [DIM_W-1:0]  r_img_rows, r_img_cols;
    logic [KDIM_W-1:0] r_ker_rows, r_ker_cols;
    logic [DIM_W-1:0]  rows, cols;
    logic [KDIM_W-1:0] kr, kc;

    logic signed [VAL_W-1:0] r_weights [MAX_KERNEL_DIM][MAX_KERNEL_DIM];
    logic signed [VAL_W-1:0] r_taps    [MAX_KERNEL_DIM][MAX_KERNEL_DIM];

    logic [POS_W-1:0] r_prow, r_pcol, e_row, e_col;
    logic [CNT_W-1:0] r_pslot, e_slot;
    logic [POS_W-1:0] r_cur_col;
    logic [CNT_W-1:0] r_cur_slot;
    logic             r_emit, r_last;
    logic [POS_W-1:0] r_orow, r_ocol;
    logic [CNT_W-1:0] r_rcnt, r_mr, r_mc;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [SUM_W-1:0]  r_acc;
    logic                     r_out_valid;
    logic signed [SUM_W-1:0]  r_conv_sum;
    logic [POS_W-1:0]         r_out_row, r_out_col;
    logic                     r_out_last;

    logic             wrap;
    logic             emit_now;
    logic [DIM_W-1:0] row_p1, col_p1;
    logic [SUMK_W-1:0] slot_sum;
    logic [CNT_W-1:0] rd_slot;
    logic [LB_AW-1:0] waddr, raddr;
    logic [VAL_W-1:0] rdata;

    assign rows = clamp_img(r_img_rows);
    assign cols = clamp_img(r_img_cols);
    assign kr   = clamp_ker(r_ker_rows);
    assign kc   = clamp_ker(r_ker_cols);

    // Position of the pixel at the port, pulled back inside the clamped image.
    always_comb begin
        wrap   = (DIM_W'(r_prow) >= rows) || (DIM_W'(r_pcol) >= cols);
        e_row  = wrap ? '0 : r_prow;
        e_col  = wrap ? '0 : r_pcol;
        e_slot = wrap ? '0 : r_pslot;
        row_p1 = DIM_W'(e_row) + DIM_W'(1);
        col_p1 = DIM_W'(e_col) + DIM_W'(1);
        emit_now = (DIM_W'(kr) <= rows) && (DIM_W'(kc) <= cols) &&
                   (row_p1 >= DIM_W'(kr)) && (col_p1 >= DIM_W'(kc));
    end

    // Ring slot of window row r_rcnt, oldest row first.
    always_comb begin
        slot_sum = SUMK_W'(r_cur_slot) + SUMK_W'(MAX_KERNEL_DIM) - SUMK_W'(kr)
                 + SUMK_W'(1) + SUMK_W'(r_rcnt);
        if (slot_sum >= SUMK_W'(MAX_KERNEL_DIM)) slot_sum = slot_sum - SUMK_W'(MAX_KERNEL_DIM);
        if (slot_sum >= SUMK_W'(MAX_KERNEL_DIM)) slot_sum = slot_sum - SUMK_W'(MAX_KERNEL_DIM);
        rd_slot = CNT_W'(slot_sum);
    end

    assign waddr = LB_AW'(e_slot) * LB_AW'(MAX_IMAGE_DIM) + LB_AW'(e_col);
    assign raddr = LB_AW'(rd_slot) * LB_AW'(MAX_IMAGE_DIM) + LB_AW'(r_cur_col);

    c2dvw_ram #(
        .WIDTH (VAL_W),
        .DEPTH (LB_DEPTH)
    ) u_line_buf (
        .i_clk   (i_clk),
        .i_we    (i_cmd.take_pixel),
        .i_waddr (waddr),
        .i_wdata (i_value),
        .i_re    (i_cmd.rd_issue),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Config, position and weights.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_rows <= DIM_W'(28);
            r_img_cols <= DIM_W'(28);
            r_ker_rows <= KDIM_W'(5);
            r_ker_cols <= KDIM_W'(5);
            r_prow     <= '0;
            r_pcol     <= '0;
            r_pslot    <= '0;
            for (int r = 0; r < MAX_KERNEL_DIM; r++) begin
                for (int c = 0; c < MAX_KERNEL_DIM; c++) begin
                    r_weights[r][c] <= '0;
                end
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_IMAGE_ROWS:  r_img_rows <= i_cfg_data;
                    REG_IMAGE_COLS:  r_img_cols <= i_cfg_data;
                    REG_KERNEL_ROWS: r_ker_rows <= i_cfg_data[KDIM_W-1:0];
                    REG_KERNEL_COLS: r_ker_cols <= i_cfg_data[KDIM_W-1:0];
                    default: ;
                endcase
                r_prow  <= '0;
                r_pcol  <= '0;
                r_pslot <= '0;
            end else if (i_cmd.take_pixel) begin
                if (col_p1 >= cols) begin
                    r_pcol <= '0;
                    if (row_p1 >= rows) begin
                        r_prow  <= '0;
                        r_pslot <= '0;
                    end else begin
                        r_prow  <= row_p1[POS_W-1:0];
                        r_pslot <= (e_slot == CNT_W'(MAX_KERNEL_DIM - 1)) ?
                                   '0 : e_slot + CNT_W'(1);
                    end
                end else begin
                    r_pcol <= col_p1[POS_W-1:0];
                end
            end
            if (i_cmd.take_weight && (i_weight_row < 3'(MAX_KERNEL_DIM)) &&
                (i_weight_col < 3'(MAX_KERNEL_DIM))) begin
                r_weights[CNT_W'(i_weight_row)][CNT_W'(i_weight_col)] <= i_value;
            end
        end
    end

    // Per-pixel working registers, taps and MAC.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_pixel) begin
            r_cur_col  <= e_col;
            r_cur_slot <= e_slot;
            r_emit     <= emit_now;
            r_last     <= (row_p1 == rows) && (col_p1 == cols);
            r_orow     <= POS_W'(row_p1 - DIM_W'(kr));
            r_ocol     <= POS_W'(col_p1 - DIM_W'(kc));
            r_rcnt     <= '0;
        end
        if (i_cmd.rd_capt) begin
            for (int c = 0; c + 1 < MAX_KERNEL_DIM; c++) begin
                if (c + 1 < int'(kc)) begin
                    r_taps[r_rcnt][c] <= r_taps[r_rcnt][c + 1];
                end
            end
            for (int c = 0; c < MAX_KERNEL_DIM; c++) begin
                if (c + 1 == int'(kc)) begin
                    r_taps[r_rcnt][c] <= rdata;
                end
            end
            r_rcnt <= r_rcnt + CNT_W'(1);
        end
        if (i_cmd.clr_acc) begin
            r_acc <= '0;
            r_mr  <= '0;
            r_mc  <= '0;
        end
        if (i_cmd.mul) begin
            r_prod <= r_taps[r_mr][r_mc] * r_weights[r_mr][r_mc];
        end
        if (i_cmd.acc) begin
            r_acc <= r_acc + {{(SUM_W - PROD_W){r_prod[PROD_W-1]}}, r_prod};
            if (r_mc == CNT_W'(kc - KDIM_W'(1))) begin
                r_mc <= '0;
                r_mr <= r_mr + CNT_W'(1);
            end else begin
                r_mc <= r_mc + CNT_W'(1);
            end
        end
        if (i_cmd.load_out) begin
            r_conv_sum <= r_acc;
            r_out_row  <= r_orow;
            r_out_col  <= r_ocol;
            r_out_last <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.row_last  = (r_rcnt == CNT_W'(kr - KDIM_W'(1)));
    assign o_sts.term_last = (r_mr == CNT_W'(kr - KDIM_W'(1))) &&
                             (r_mc == CNT_W'(kc - KDIM_W'(1)));
    assign o_sts.emit      = r_emit;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_conv_sum      = r_conv_sum;
    assign o_out_row       = r_out_row;
    assign o_out_col       = r_out_col;
    assign o_last_of_image = r_out_last;

    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("output register overwritten before it was taken");

    a_pending_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> r_out_valid)
        else $error("pending result dropped");

    a_load_only_on_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> r_emit)
        else $error("result produced for a pixel outside the valid window");
endmodule

// ===== hw/rtl/conv2d_valid_window.sv =====
// Top level of the 2-D valid convolution block: joins controller and datapath
// to the input and output channels. Depends on c2dvw_pkg, c2dvw_in_if,
// c2dvw_out_if, c2dvw_ctrl and c2dvw_dp.
//
// Usage: load kernel weights as weight beats (kind 0, row and column of the
// weight), then stream image pixels (kind 1) in raster order. Each pixel is
// written into a ring of line buffers held in one RAM, and the window taps
// shift by one column. Once the kernel window lies fully inside the image,
// the pixel yields one result beat with the window sum, its position in the
// valid output, and a flag on the last result of the image.
// Sequence: a weight beat is taken while the controller is idle. A pixel beat
// that yields no result reads each of the kr window rows from the single
// line-buffer read port and then shifts it in. A pixel that yields a result
// also forms its kr*kc products on the one shared multiplier, each product
// formed and then added to the accumulator, and a final step moves the sum to
// the output register. Input ready is high only while the controller is idle.
// The output register decouples the sides: a new item is taken while a
// result still waits; if the receiver stalls, the next result waits in the
// controller until the output register is free, and no result is lost.
// Reset restores the default sizes (28 by 28 image, 5 by 5 kernel), clears
// the weights to zero and the position to row 0, column 0. The line buffer
// needs no clearing pass. Any config write restarts the image position.
module conv2d_valid_window import c2dvw_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    c2dvw_in_if.sink              i_in,
    c2dvw_out_if.source           o_out
);
    t_cmd cmd;
    t_sts sts;
    logic in_ready;

    // The controller decides when beats are taken and sequences the datapath.
    c2dvw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_kind  (i_in.kind),
        .i_sts      (sts),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    assign i_in.ready = in_ready;

    // The datapath holds all storage and arithmetic.
    c2dvw_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_weight_row    (i_in.weight_row),
        .i_weight_col    (i_in.weight_col),
        .i_value         (i_in.value),
        .i_out_ready     (o_out.ready),
        .o_out_valid     (o_out.valid),
        .o_conv_sum      (o_out.conv_sum),
        .o_out_row       (o_out.out_row),
        .o_out_col       (o_out.out_col),
        .o_last_of_image (o_out.last_of_image)
    );
endmodule

// ===== test/conv2d_valid_window_tb.sv =====
// Testbench for conv2d_valid_window: random and directed weight and pixel beats,
// checked against a predictor of the valid 2-D convolution.
// Depends on c2dvw_pkg, c2dvw_in_if, c2dvw_out_if and the block's RTL.
module testbench;
    import c2dvw_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 4000000;

    typedef struct packed {
        logic                    kind;
        logic [2:0]              weight_row;
        logic [2:0]              weight_col;
        logic signed [VAL_W-1:0] value;
    } t_beat;

    typedef struct packed {
        logic signed [SUM_W-1:0] conv_sum;
        logic [POS_W-1:0]        out_row;
        logic [POS_W-1:0]        out_col;
        logic                    last_of_image;
    } t_result;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    c2dvw_in_if  in_ch ();
    c2dvw_out_if out_ch ();

    conv2d_valid_window dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_in      (in_ch.sink),
        .o_out     (out_ch.source)
    );

    // Predictor state: a private copy of the block's sizes, weights, line
    // buffers, window taps and raster position.
    int unsigned img_rows, img_cols, ker_rows, ker_cols;
    logic signed [VAL_W-1:0] weights [MAX_KERNEL_DIM][MAX_KERNEL_DIM];
    logic signed [VAL_W-1:0] lines   [MAX_KERNEL_DIM][MAX_IMAGE_DIM];
    logic signed [VAL_W-1:0] taps    [MAX_KERNEL_DIM][MAX_KERNEL_DIM];
    int unsigned pix_row, pix_col;

    t_beat   pending_beats[$];
    t_result expected_sums[$];
    int      error_count;
    int      cycle_count;
    int      send_gap;
    int      recv_gap;

    function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // Applies one accepted beat to the predictor and queues the result it causes.
    task automatic predict_beat(input t_beat b);
        int unsigned rows, cols, kr, kc, slot;
        logic signed [63:0] acc;
        t_result res;
        rows = clamp_size(img_rows, MAX_IMAGE_DIM);
        cols = clamp_size(img_cols, MAX_IMAGE_DIM);
        kr = clamp_size(ker_rows, MAX_KERNEL_DIM);
        kc = clamp_size(ker_cols, MAX_KERNEL_DIM);
        if (b.kind == KIND_WEIGHT) begin
            if (b.weight_row < MAX_KERNEL_DIM && b.weight_col < MAX_KERNEL_DIM)
                weights[b.weight_row][b.weight_col] = b.value;
            return;
        end
        if (pix_row >= rows || pix_col >= cols) begin
            pix_row = 0;
            pix_col = 0;
        end
        lines[pix_row % MAX_KERNEL_DIM][pix_col] = b.value;
        for (int r = 0; r < kr; r++) begin
            slot = (pix_row + MAX_KERNEL_DIM - (kr - 1) + r) % MAX_KERNEL_DIM;
            for (int c = 0; c + 1 < kc; c++) taps[r][c] = taps[r][c + 1];
            taps[r][kc - 1] = lines[slot][pix_col];
        end
        if (kr <= rows && kc <= cols && pix_row + 1 >= kr && pix_col + 1 >= kc) begin
            acc = 0;
            for (int r = 0; r < kr; r++)
                for (int c = 0; c < kc; c++)
                    acc += 64'(taps[r][c]) * 64'(weights[r][c]);
            res.conv_sum = acc[SUM_W-1:0];
            res.out_row = POS_W'(pix_row + 1 - kr);
            res.out_col = POS_W'(pix_col + 1 - kc);
            res.last_of_image = (pix_row + 1 == rows) && (pix_col + 1 == cols);
            expected_sums.push_back(res);
        end
        pix_col++;
        if (pix_col >= cols) begin
            pix_col = 0;
            pix_row++;
            if (pix_row >= rows) pix_row = 0;
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    function automatic int pick_gap();
        // Often back-to-back, mostly short gaps, and a rare long one.
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40) return 0;
        if (sel < 95) return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Driver: presents the head of the pending queue, with random gaps
    // between beats. The predictor sees each beat on acceptance.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_beat(pending_beats.pop_front());
                send_gap = pick_gap();
            end
            if (send_gap > 0) begin
                send_gap--;
                in_ch.valid <= 1'b0;
            end else if (pending_beats.size() > 0) begin
                in_ch.valid      <= 1'b1;
                in_ch.kind       <= pending_beats[0].kind;
                in_ch.weight_row <= pending_beats[0].weight_row;
                in_ch.weight_col <= pending_beats[0].weight_col;
                in_ch.value      <= pending_beats[0].value;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each accepted result beat against the oldest expectation
    // and stalls the output channel at random.
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            recv_gap = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_sums.size() == 0) begin
                    report_mismatch("unexpected result", out_ch.conv_sum, 0);
                end else begin
                    want = expected_sums.pop_front();
                    if (out_ch.conv_sum !== want.conv_sum)
                        report_mismatch("conv_sum", out_ch.conv_sum, want.conv_sum);
                    if (out_ch.out_row !== want.out_row)
                        report_mismatch("out_row", out_ch.out_row, want.out_row);
                    if (out_ch.out_col !== want.out_col)
                        report_mismatch("out_col", out_ch.out_col, want.out_col);
                    if (out_ch.last_of_image !== want.last_of_image)
                        report_mismatch("last_of_image", out_ch.last_of_image,
                                        want.last_of_image);
                end
                recv_gap = pick_gap();
            end
            if (recv_gap > 0) begin
                recv_gap--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog on the total cycle count.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic t_beat weight_beat(input int r, input int c, input int v);
        t_beat b;
        b.kind = KIND_WEIGHT;
        b.weight_row = 3'(r);
        b.weight_col = 3'(c);
        b.value = VAL_W'(v);
        return b;
    endfunction

    function automatic t_beat pixel_beat(input int v);
        t_beat b;
        b.kind = KIND_PIXEL;
        b.weight_row = 3'($urandom_range(0, 7));
        b.weight_col = 3'($urandom_range(0, 7));
        b.value = VAL_W'(v);
        return b;
    endfunction

    function automatic int random_value();
        // Full range most of the time, extremes now and then.
        case ($urandom_range(0, 7))
            0: return -32768;
            1: return 32767;
            default: return int'($signed(16'($urandom())));
        endcase
    endfunction

    // Waits until the block has drained everything sent so far.
    task automatic wait_drained();
        while (pending_beats.size() > 0 || in_ch.valid || expected_sums.size() > 0)
            @(posedge i_clk);
        // A trailing pixel with no result may still be in flight.
        repeat (2 * MAX_KERNEL_DIM + 8) @(posedge i_clk);
    endtask

    // Register write while idle; the predictor restarts its raster position.
    // The enable drops for one cycle so that back-to-back writes stay apart.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DATA_W'(val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_IMAGE_ROWS:  img_rows = val & 7'h7f;
            REG_IMAGE_COLS:  img_cols = val & 7'h7f;
            REG_KERNEL_ROWS: ker_rows = val & 3'h7;
            default:         ker_cols = val & 3'h7;
        endcase
        pix_row = 0;
        pix_col = 0;
        @(posedge i_clk);
    endtask

    task automatic set_sizes(input int ir, input int ic, input int kr, input int kc);
        wait_drained();
        write_reg(REG_IMAGE_ROWS, ir);
        write_reg(REG_IMAGE_COLS, ic);
        write_reg(REG_KERNEL_ROWS, kr);
        write_reg(REG_KERNEL_COLS, kc);
    endtask

    task automatic load_kernel();
        for (int r = 0; r < MAX_KERNEL_DIM; r++)
            for (int c = 0; c < MAX_KERNEL_DIM; c++)
                pending_beats.push_back(weight_beat(r, c, random_value()));
    endtask

    task automatic send_pixels(input int count);
        for (int i = 0; i < count; i++) pending_beats.push_back(pixel_beat(random_value()));
    endtask

    initial begin
        int sent, ir, ic, kr, kc, npix;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.kind = KIND_WEIGHT;
        in_ch.weight_row = '0;
        in_ch.weight_col = '0;
        in_ch.value = '0;
        out_ch.ready = 1'b0;
        error_count = 0;
        cycle_count = 0;
        img_rows = 28; img_cols = 28; ker_rows = 5; ker_cols = 5;
        pix_row = 0; pix_col = 0;
        foreach (weights[r, c]) weights[r][c] = '0;
        foreach (lines[r, c]) lines[r][c] = '0;
        foreach (taps[r, c]) taps[r][c] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: extreme weights, ignored out-of-range weight indices,
        // then a tiny 2x2 image with a 2x2 kernel at the extremes.
        set_sizes(2, 2, 2, 2);
        pending_beats.push_back(weight_beat(0, 0, -32768));
        pending_beats.push_back(weight_beat(0, 1, 32767));
        pending_beats.push_back(weight_beat(1, 0, -32768));
        pending_beats.push_back(weight_beat(1, 1, -32768));
        pending_beats.push_back(weight_beat(7, 0, 1234));
        pending_beats.push_back(weight_beat(2, 5, 4321));
        pending_beats.push_back(weight_beat(4, 4, 100));
        pending_beats.push_back(pixel_beat(-32768));
        pending_beats.push_back(pixel_beat(32767));
        pending_beats.push_back(pixel_beat(-32768));
        pending_beats.push_back(pixel_beat(-32768));
        // Image wrap: a second image straight after the first.
        send_pixels(4);
        // Kernel larger than image: pixels are consumed, no results.
        set_sizes(2, 3, 3, 1);
        send_pixels(6);
        // Zero registers act as 1; over-range registers clamp to the maximum.
        set_sizes(0, 0, 0, 0);
        send_pixels(3);
        set_sizes(127, 3, 7, 7);
        send_pixels(4);

        // Random part: random kernel sizes with random images, mostly small.
        sent = 0;
        while (sent < 1500) begin
            case ($urandom_range(0, 9))
                0: begin ir = 64; ic = $urandom_range(1, 6); end
                1: begin ir = $urandom_range(1, 4); ic = 64; end
                2: begin ir = $urandom_range(0, 127); ic = $urandom_range(0, 127); end
                default: begin ir = $urandom_range(1, 8); ic = $urandom_range(1, 8); end
            endcase
            kr = $urandom_range(0, 7);
            kc = $urandom_range(0, 7);
            set_sizes(ir, ic, kr, kc);
            if ($urandom_range(0, 2) == 0) begin
                load_kernel();
                sent += 25;
            end
            npix = clamp_size(ir, MAX_IMAGE_DIM) * clamp_size(ic, MAX_IMAGE_DIM);
            if (npix > 150) npix = 150;
            npix = npix + $urandom_range(0, 5);
            // Now and then a stray weight beat lands in the middle of an image.
            for (int i = 0; i < npix; i++) begin
                if ($urandom_range(0, 19) == 0)
                    pending_beats.push_back(weight_beat($urandom_range(0, 7),
                                            $urandom_range(0, 7), random_value()));
                pending_beats.push_back(pixel_beat(random_value()));
            end
            sent += npix;
        end

        wait_drained();
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
hw/rtl/c2dvw_pkg.sv
hw/rtl/c2dvw_in_if.sv
hw/rtl/c2dvw_out_if.sv
hw/rtl/c2dvw_ram.sv
hw/rtl/c2dvw_ctrl.sv
hw/rtl/c2dvw_dp.sv
hw/rtl/conv2d_valid_window.sv
test/conv2d_valid_window_tb.sv
